// ===== hdl/tws_pkg.sv =====
// ----------------------------------------------------------------------------
// tws_pkg
// operation and status codes, sequencer states and compare result type
// ----------------------------------------------------------------------------
package tws_pkg;

  localparam logic [1:0] OP_ENQUEUE = 2'd0;
  localparam logic [1:0] OP_MARK    = 2'd1;
  localparam logic [1:0] OP_SCAN    = 2'd2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_FULL     = 2'd1;
  localparam logic [1:0] STATUS_NOTFOUND = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_SHIFT = 4'b0100,
    ST_RESP  = 4'b1000
  } state_t;

  typedef struct packed {
    logic late;         // entry deadline below current time
    logic below_least;  // entry deadline below running minimum
    logic task_match;   // entry task equals requested task
  } cmp_t;

endpackage

// ===== hdl/tws_list_mem.sv =====
// ----------------------------------------------------------------------------
// tws_list_mem
// list storage, one write port and one registered read port
// ----------------------------------------------------------------------------
module tws_list_mem #(
  parameter int DEPTH  = 16,
  parameter int WIDTH  = 41,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/tws_cmp.sv =====
// ----------------------------------------------------------------------------
// tws_cmp
// shared compare unit applied to one list entry per cycle
// ----------------------------------------------------------------------------
module tws_cmp import tws_pkg::*; #(
  parameter int TASK_BITS = 8,
  parameter int TIME_BITS = 32
) (
  input  logic [TASK_BITS-1:0] entry_task,
  input  logic [TIME_BITS-1:0] entry_deadline,
  input  logic [TASK_BITS-1:0] want_task,
  input  logic [TIME_BITS-1:0] now,
  input  logic [TIME_BITS-1:0] least,
  output cmp_t                 res
);

  always_comb begin
    res.late        = entry_deadline < now;
    res.below_least = entry_deadline < least;
    res.task_match  = entry_task == want_task;
  end

endmodule

// ===== hdl/timeout_wait_queue_scan.sv =====
// ----------------------------------------------------------------------------
// timeout_wait_queue_scan
// ordered wait list of tasks with deadline and data-arrived scan
// ----------------------------------------------------------------------------
// usage:
//   requests enter on the s_ group (tvalid/tready/tdata/tuser), tuser holds the
//   operation: enqueue, mark data arrived, scan and serve. every request gives
//   exactly one result on the m_ group.
//   the list lives in a single-port-read memory in list order; a small
//   sequencer walks it one entry per cycle through one shared compare unit.
//   steps per request:
//     enqueue or unknown operation : goes straight to result load
//     mark data                    : walks the list, stops at first match
//     scan without hit             : walks the whole list
//     scan with hit                : stops at the hit; the tail after the hit
//                                    is moved down one entry a cycle
//   the read-then-write memory path sets the one-entry-a-cycle pace.
//   s_tready is high only between requests; one request is worked at a time.
//   a finished result sits in the output register; if the receiver stalls,
//   the next request is still taken and waits at its result until m_tready.
//   reset clears the entry count and the handshake state; memory contents are
//   left as they are and are never read before written.
// ----------------------------------------------------------------------------
module timeout_wait_queue_scan import tws_pkg::*; #(
  parameter int LIST_DEPTH = 16,
  parameter int TASK_BITS  = 8,
  parameter int TIME_BITS  = 32
) (
  input  logic clk,
  input  logic rst,
  // request channel
  input  logic                                          s_tvalid,
  output logic                                          s_tready,
  // tdata, from bit 0: task_number, deadline, current_time
  input  logic [((TASK_BITS+2*TIME_BITS+7)/8)*8-1:0]    s_tdata,
  // tuser: operation
  input  logic [1:0]                                    s_tuser,
  // result channel
  output logic                                          m_tvalid,
  input  logic                                          m_tready,
  // tdata, from bit 0: served, served_task, timed_out, next_timeout, status
  output logic [((TASK_BITS+TIME_BITS+4+7)/8)*8-1:0]    m_tdata
);

  localparam int IDX_W  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
  localparam int ENT_W  = TASK_BITS + TIME_BITS + 1;
  localparam int OUT_W  = TASK_BITS + TIME_BITS + 4;
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(LIST_DEPTH);

  // request fields
  logic [TASK_BITS-1:0] in_task;
  logic [TIME_BITS-1:0] in_deadline;
  logic [TIME_BITS-1:0] in_now;
  logic                 s_fire;

  // sequencer state
  state_t               state;
  logic [CNT_W-1:0]     count;     // entries in the list
  logic [CNT_W-1:0]     rd_idx;    // next list position to read
  logic                 pend;      // read data valid this cycle
  logic [IDX_W-1:0]     pos;       // list position of the data in rd_data
  logic [TIME_BITS-1:0] least;     // running minimum deadline
  logic [1:0]           op_r;
  logic [TASK_BITS-1:0] task_r;
  logic [TIME_BITS-1:0] now_r;

  assign in_task     = s_tdata[TASK_BITS-1:0];
  assign in_deadline = s_tdata[TASK_BITS +: TIME_BITS];
  assign in_now      = s_tdata[TASK_BITS+TIME_BITS +: TIME_BITS];
  assign s_tready    = (state == ST_IDLE);
  assign s_fire      = s_tvalid && s_tready;

  // pending result
  logic                 res_served;
  logic [TASK_BITS-1:0] res_task;
  logic                 res_tmo;
  logic [TIME_BITS-1:0] res_next;
  logic [1:0]           res_status;

  // output register
  logic                 out_served;
  logic [TASK_BITS-1:0] out_task;
  logic                 out_tmo;
  logic [TIME_BITS-1:0] out_next;
  logic [1:0]           out_status;

  // memory ports
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [ENT_W-1:0] wr_data;
  logic             issue;
  logic [ENT_W-1:0] rd_data;

  // current entry fields
  logic [TASK_BITS-1:0] e_task;
  logic [TIME_BITS-1:0] e_deadline;
  logic                 e_ready;
  cmp_t                 cmp;
  logic                 scan_hit;
  logic                 mark_hit;
  logic                 walk_done;

  assign e_task     = rd_data[TASK_BITS-1:0];
  assign e_deadline = rd_data[TASK_BITS +: TIME_BITS];
  assign e_ready    = rd_data[ENT_W-1];

  // one read per cycle while list positions remain
  assign issue = ((state == ST_SCAN) || (state == ST_SHIFT)) && (rd_idx < count);
  assign walk_done = !pend && !issue;
  assign scan_hit  = pend && (e_ready || cmp.late);
  assign mark_hit  = pend && cmp.task_match;

  tws_list_mem #(
    .DEPTH  (LIST_DEPTH),
    .WIDTH  (ENT_W),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (issue),
    .rd_addr (rd_idx[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  tws_cmp #(
    .TASK_BITS (TASK_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_cmp (
    .entry_task     (e_task),
    .entry_deadline (e_deadline),
    .want_task      (task_r),
    .now            (now_r),
    .least          (least),
    .res            (cmp)
  );

  // memory write: append at tail, set data flag, or move tail entry down
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos;
    wr_data = rd_data;
    case (state)
      ST_IDLE: begin
        if (s_fire && (s_tuser == OP_ENQUEUE) && (count != FULL_COUNT)) begin
          wr_en   = 1'b1;
          wr_addr = count[IDX_W-1:0];
          wr_data = {1'b0, in_deadline, in_task};
        end
      end
      ST_SCAN: begin
        if ((op_r == OP_MARK) && mark_hit) begin
          wr_en   = 1'b1;
          wr_addr = pos;
          wr_data = {1'b1, e_deadline, e_task};
        end
      end
      ST_SHIFT: begin
        if (pend) begin
          wr_en   = 1'b1;
          wr_addr = pos - IDX_W'(1);
          wr_data = rd_data;
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      pend     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // in ST_RESP the output register is reloaded below
      if (m_tvalid && m_tready && (state != ST_RESP)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_fire) begin
            op_r       <= s_tuser;
            task_r     <= in_task;
            now_r      <= in_now;
            rd_idx     <= '0;
            pend       <= 1'b0;
            least      <= '1;
            res_served <= 1'b0;
            res_task   <= '0;
            res_tmo    <= 1'b0;
            res_next   <= '0;
            res_status <= ((s_tuser == OP_ENQUEUE) && (count == FULL_COUNT)) ?
                          STATUS_FULL : STATUS_OK;
            case (s_tuser)
              OP_ENQUEUE: begin
                if (count != FULL_COUNT) begin
                  count <= count + CNT_W'(1);
                end
                state <= ST_RESP;
              end
              OP_MARK, OP_SCAN: begin
                state <= ST_SCAN;
              end
              default: begin
                state <= ST_RESP;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if ((op_r != OP_MARK) && scan_hit) begin
            // data takes precedence over timeout
            res_served <= 1'b1;
            res_task   <= e_task;
            res_tmo    <= !e_ready;
            res_next   <= least;
            rd_idx     <= CNT_W'(pos) + CNT_W'(1);
            pend       <= 1'b0;
            state      <= ST_SHIFT;
          end else begin
            pend <= issue;
            if (issue) begin
              rd_idx <= rd_idx + CNT_W'(1);
              pos    <= rd_idx[IDX_W-1:0];
            end
            if (op_r == OP_MARK) begin
              if (mark_hit) begin
                state <= ST_RESP;
              end else if (walk_done) begin
                res_status <= STATUS_NOTFOUND;
                state      <= ST_RESP;
              end
            end else begin
              if (pend && cmp.below_least) begin
                least <= e_deadline;
              end
              if (walk_done) begin
                res_next <= least;
                state    <= ST_RESP;
              end
            end
          end
        end
        ST_SHIFT: begin
          pend <= issue;
          if (issue) begin
            rd_idx <= rd_idx + CNT_W'(1);
            pos    <= rd_idx[IDX_W-1:0];
          end
          if (walk_done) begin
            count <= count - CNT_W'(1);
            state <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (!m_tvalid || m_tready) begin
            out_served <= res_served;
            out_task   <= res_task;
            out_tmo    <= res_tmo;
            out_next   <= res_next;
            out_status <= res_status;
            m_tvalid   <= 1'b1;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = OUT_TW'({out_status, out_next, out_tmo, out_task, out_served});

`ifndef NO_ASSERTIONS
  // entry count stays within the list
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("entry count beyond list depth");

  // compaction never writes below the head of the list
  a_shift_pos: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHIFT) && pend |-> pos != '0)
    else $error("compaction write below head");

  // leaving compaction removes exactly one entry
  a_shift_dec: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHIFT) ##1 (state == ST_RESP) |-> count == $past(count) - CNT_W'(1))
    else $error("served entry not removed");

  // a served entry is always reported with ok status
  a_served_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_served |-> out_status == STATUS_OK)
    else $error("served result with error status");
`endif

endmodule
